// ----- hw/rtl/rmbd_pkg.sv -----
// Shared types and constants for the RGBA mip pyramid downsampler.
package rmbd_pkg;
	localparam int MaxWidth = 4096;
	localparam int MaxLevels = 13;
	localparam int LvlW = 4;
	localparam int PosW = 12;
	localparam int AddrW = 12;
	localparam logic [1:0] CfgWidth = 2'd0;
	localparam logic [1:0] CfgHeight = 2'd1;
	localparam logic [1:0] CfgLevels = 2'd2;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pix_t;

	typedef struct packed {
		logic [9:0] r;
		logic [9:0] g;
		logic [9:0] b;
		logic [9:0] a;
	} psum_t;

	typedef struct packed {
		logic [LvlW-1:0] lvl;
		logic [PosW-1:0] x;
		logic [PosW-1:0] y;
		pix_t px;
		logic last;
	} res_t;
endpackage

// ----- hw/rtl/rmbd_fifo.sv -----
// Two-entry input request queue between the front end and the level engine.
module rmbd_fifo import rmbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pix_t in_px,
	output logic out_valid,
	input  logic out_ready,
	output pix_t out_px
);
	pix_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_px = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_px;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready) else $error("queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("bad count");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop lost");
`endif
endmodule

// ----- hw/rtl/rmbd_engine.sv -----
// Level engine: walks the pyramid levels for one pixel, one level at a time (emit, read, sum).
module rmbd_engine import rmbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic restart,
	input  logic [12:0] w0,
	input  logic [12:0] h0,
	input  logic [LvlW-1:0] levels,
	input  logic in_valid,
	output logic in_ready,
	input  pix_t in_px,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);
	typedef enum logic [1:0] {S_IDLE, S_EMIT, S_READ, S_SUM} state_t;
	state_t state_q;

	logic [PosW-1:0] col_q [MaxLevels];
	logic [PosW-1:0] row_q [MaxLevels];
	pix_t hold_q [MaxLevels];
	psum_t mem [MaxWidth];
	psum_t rd_q;
	pix_t cur_q;
	psum_t pair_q;
	logic [LvlW-1:0] lvl_q;
	logic [AddrW:0] base_q;
	logic [AddrW:0] idx_q;
	logic [12:0] wl, hl;
	logic [PosW-1:0] c, r;
	logic last_lvl;
	logic [AddrW:0] idx;
	psum_t pair;
	logic [11:0] sr, sg, sb, sa;

	assign wl = w0 >> lvl_q;
	assign hl = h0 >> lvl_q;
	assign c = col_q[lvl_q];
	assign r = row_q[lvl_q];
	assign last_lvl = ({1'b0, lvl_q} + 5'd1) >= {1'b0, levels};
	assign idx = base_q + {2'b0, c[PosW-1:1]};
	assign pair.r = {2'b0, hold_q[lvl_q].r} + {2'b0, cur_q.r};
	assign pair.g = {2'b0, hold_q[lvl_q].g} + {2'b0, cur_q.g};
	assign pair.b = {2'b0, hold_q[lvl_q].b} + {2'b0, cur_q.b};
	assign pair.a = {2'b0, hold_q[lvl_q].a} + {2'b0, cur_q.a};
	assign sr = {2'b0, rd_q.r} + {2'b0, pair_q.r};
	assign sg = {2'b0, rd_q.g} + {2'b0, pair_q.g};
	assign sb = {2'b0, rd_q.b} + {2'b0, pair_q.b};
	assign sa = {2'b0, rd_q.a} + {2'b0, pair_q.a};
	assign in_ready = state_q == S_IDLE;

	logic chain;
	assign chain = !last_lvl && c[0] && !idx[AddrW] && r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			lvl_q <= '0;
			base_q <= '0;
			for (int i = 0; i < MaxLevels; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else if (restart) begin
			for (int i = 0; i < MaxLevels; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_q <= in_px;
						lvl_q <= '0;
						base_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_res.lvl <= lvl_q;
						out_res.x <= c;
						out_res.y <= r;
						out_res.px <= cur_q;
						out_res.last <= !chain;
						if ({1'b0, c} + 13'd1 >= wl) begin
							col_q[lvl_q] <= '0;
							row_q[lvl_q] <= ({1'b0, r} + 13'd1 >= hl) ? '0 : r + 12'd1;
						end else begin
							col_q[lvl_q] <= c + 12'd1;
						end
						pair_q <= pair;
						idx_q <= idx;
						if (!last_lvl && !c[0]) hold_q[lvl_q] <= cur_q;
						state_q <= chain ? S_READ : S_IDLE;
					end
				end
				S_READ: state_q <= S_SUM;
				S_SUM: begin
					cur_q <= {sr[9:2], sg[9:2], sb[9:2], sa[9:2]};
					base_q <= base_q + {1'b0, wl[12:1]};
					lvl_q <= lvl_q + 4'd1;
					state_q <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic wr_en;
	assign wr_en = state_q == S_EMIT && (!out_valid || out_ready) && !restart
		&& !last_lvl && c[0] && !idx[AddrW] && !r[0];

	always_ff @(posedge clk) begin
		if (wr_en) mem[idx[AddrW-1:0]] <= pair;
		rd_q <= mem[idx_q[AddrW-1:0]];
	end

`ifndef SYNTHESIS
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> lvl_q < levels) else $error("level past count");
	a_read_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && !restart) |=> state_q == S_SUM) else $error("sum skipped");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !out_valid && !restart && !chain) |=> state_q == S_IDLE)
		else $error("run not closed");
`endif
endmodule

// ----- hw/rtl/rgba_mipmap_box_downsampler_unit.sv -----
// Top level of the RGBA mip pyramid downsampler.
// Input channel: valid/ready with red, green, blue, alpha, one level-0 pixel per
// request in raster order. Output channel: valid/ready, one request per produced
// pixel with mip_level, pos_x, pos_y, channels and last_of_run on the final one.
// A two-entry queue decouples the input from the level engine.
// Each level's result is emitted from the emit state; stepping down a level
// then passes the pair-sum memory read state and the add state. The engine
// takes a new pixel only when idle, once the current one's run is emitted.
// Configuration writes (cfg_we, cfg_index, cfg_data) to width, height or
// levels restart the frame: position counters of all levels go to zero.
// Reset loads width 256, height 256, one level. When the receiver stalls,
// the engine holds its result and stops; the queue then fills and input
// ready drops.
module rgba_mipmap_box_downsampler_unit import rmbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [12:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	output logic out_valid,
	input  logic out_ready,
	output logic [3:0] mip_level,
	output logic [11:0] pos_x,
	output logic [11:0] pos_y,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic [7:0] out_alpha,
	output logic last_of_run
);
	logic [12:0] width_q, height_q;
	logic [3:0] levels_q;
	logic [12:0] w0, h0;
	logic [3:0] lv;
	logic q_valid, q_ready;
	pix_t q_px;
	res_t res;
	logic restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd256;
			height_q <= 13'd256;
			levels_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgWidth: width_q <= cfg_data;
				CfgHeight: height_q <= cfg_data;
				CfgLevels: levels_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign w0 = (width_q == 13'd0) ? 13'd1 : (width_q > 13'd4096) ? 13'd4096 : width_q;
	assign h0 = (height_q == 13'd0) ? 13'd1 : (height_q > 13'd4096) ? 13'd4096 : height_q;
	assign lv = (levels_q == 4'd0) ? 4'd1 : (levels_q > 4'd13) ? 4'd13 : levels_q;
	assign restart = cfg_we && (cfg_index == CfgWidth || cfg_index == CfgHeight
		|| cfg_index == CfgLevels);

	rmbd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_px({red, green, blue, alpha}),
		.out_valid(q_valid), .out_ready(q_ready), .out_px(q_px)
	);

	rmbd_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.restart(restart),
		.w0(w0), .h0(h0), .levels(lv),
		.in_valid(q_valid), .in_ready(q_ready), .in_px(q_px),
		.out_valid(out_valid), .out_ready(out_ready), .out_res(res)
	);

	assign mip_level = res.lvl;
	assign pos_x = res.x;
	assign pos_y = res.y;
	assign out_red = res.px.r;
	assign out_green = res.px.g;
	assign out_blue = res.px.b;
	assign out_alpha = res.px.a;
	assign last_of_run = res.last;
endmodule
